[rtl/core/htsc_pkg.sv]
// Shared types, constants and widths for the head tracker sample conditioner.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package htsc_pkg;

  // Moving-average window and calibration length.
  localparam int WINDOW      = 100;
  localparam int CAL_SAMPLES = 100;

  // Ring and running-sum widths follow from the window.
  localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = 16 + $clog2(WINDOW);
  localparam int CMP_W   = SUM_W + 1;

  // Calibration counter and sum widths follow from the calibration length.
  localparam int CAL_CNT_W = $clog2(CAL_SAMPLES + 2);
  localparam int AZ_TOT_W  = 15 + $clog2(CAL_SAMPLES);
  localparam int EL_TOT_W  = 14 + $clog2(CAL_SAMPLES);

  // Constant divider: quotient estimate by reciprocal, then one correction.
  localparam int DIV_W     = AZ_TOT_W;
  localparam int DIV_SH    = DIV_W;
  localparam int RECIP_W   = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SH) / CAL_SAMPLES);

  // Front-to-back queue.
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCNT_W = 2;

  // Port widths.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_DATA_W  = 16;

  // Input opcodes.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_CAL    = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic REG_STEP_THRESHOLD = 1'b0;
  localparam logic REG_LOCKOUT_TICKS  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [14:0]      THR_RESET     = 15'd154;
  localparam logic [SUM_W-1:0] THR_SC_RESET  = SUM_W'(WINDOW * 154);
  localparam logic [15:0]      LOCKOUT_RESET = 16'd500;

  // One full turn in 1/64 degree.
  localparam logic signed [16:0] AZ_FULL_TURN = 17'sd23040;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_CAL,
    KIND_TICK
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [14:0]        az;
    logic signed [13:0] el;
    logic signed [15:0] acc;
  } item_t;

  typedef struct packed {
    item_t                   item;
    logic signed [SUM_W-1:0] total;
  } ring_item_t;

  typedef struct packed {
    logic               valid;
    logic [14:0]        az;
    logic signed [14:0] el;
    logic               step;
    logic               done;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/htsc_front.sv]
// Front part: accepts input items, classifies them by opcode and queues them.
// Depends on htsc_pkg for the item type and queue depth.
`default_nettype none

module htsc_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [htsc_pkg::IN_TDATA_W-1:0] in_tdata,  // azimuth_in, elevation_in, accel_z
  input  wire [htsc_pkg::IN_TUSER_W-1:0] in_tuser,  // opcode
  output logic                         q_valid,
  input  wire                          q_pop,
  output htsc_pkg::item_t              q_item
);
  import htsc_pkg::*;

  item_t             qmem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  item_t             cls_item;
  logic              cls_keep;
  logic              push;

  // Classify the incoming item; the unused opcode is accepted and dropped.
  always_comb begin
    cls_item.az   = in_tdata[14:0];
    cls_item.el   = in_tdata[28:15];
    cls_item.acc  = in_tdata[44:29];
    cls_item.kind = KIND_SAMPLE;
    cls_keep      = 1'b1;
    case (in_tuser)
      OP_SAMPLE: cls_item.kind = KIND_SAMPLE;
      OP_CAL:    cls_item.kind = KIND_CAL;
      OP_TICK:   cls_item.kind = KIND_TICK;
      default:   cls_keep      = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready && cls_keep;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = qmem_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      qmem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

[rtl/core/htsc_ring.sv]
// Back part, first stage: acceleration ring memory and the running window sum.
// Depends on htsc_pkg for the item types and ring geometry.
`default_nettype none

module htsc_ring (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  htsc_pkg::item_t      q_item,
  output logic                 q_pop,
  input  wire                  b_ready,
  output logic                 a_valid,
  output htsc_pkg::ring_item_t a_out
);
  import htsc_pkg::*;

  logic signed [15:0]      ring_mem [WINDOW];
  logic [WINDOW-1:0]       ent_vld_r;
  logic signed [15:0]      rd_data_r;
  logic                    rd_vld_r;
  logic                    a_vld_r;
  item_t                   a_item_r;
  logic [RING_AW-1:0]      a_pos_r;
  logic [RING_AW-1:0]      pos_r, pos_nxt;
  logic signed [SUM_W-1:0] total_r;
  logic signed [SUM_W-1:0] total_new;
  logic signed [15:0]      old_acc;
  logic                    a_ready;
  logic                    a_fire;
  logic                    q_is_samp;
  logic                    a_is_samp;

  assign a_ready   = !a_vld_r || b_ready;
  assign q_pop     = q_valid && a_ready;
  assign a_fire    = a_vld_r && b_ready;
  assign q_is_samp = (q_item.kind == KIND_SAMPLE);
  assign a_is_samp = (a_item_r.kind == KIND_SAMPLE);
  assign pos_nxt   = (pos_r == RING_AW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;

  // An entry never written since reset reads as zero.
  assign old_acc   = rd_vld_r ? rd_data_r : 16'sd0;
  assign total_new = total_r + SUM_W'(a_item_r.acc) - SUM_W'(old_acc);

  assign a_valid     = a_vld_r;
  assign a_out.item  = a_item_r;
  assign a_out.total = total_new;

  // Stage control, ring position, running sum and entry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      pos_r     <= '0;
      total_r   <= '0;
      ent_vld_r <= '0;
    end else begin
      if (a_ready) begin
        a_vld_r <= q_valid;
      end
      if (q_pop && q_is_samp) begin
        pos_r <= pos_nxt;
      end
      if (a_fire && a_is_samp) begin
        total_r            <= total_new;
        ent_vld_r[a_pos_r] <= 1'b1;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_item_r <= q_item;
      a_pos_r  <= pos_r;
    end
  end

  // Ring memory: read when a sample enters, write when it leaves.
  always_ff @(posedge clk) begin
    if (q_pop && q_is_samp) begin
      rd_data_r <= ring_mem[pos_r];
      rd_vld_r  <= ent_vld_r[pos_r];
    end
    if (a_fire && a_is_samp) begin
      ring_mem[a_pos_r] <= a_item_r.acc;
    end
  end

endmodule

`default_nettype wire

[rtl/core/htsc_cdiv.sv]
// Pipelined signed division by the calibration length, truncated toward zero.
// Depends on htsc_pkg for the divider width and the reciprocal constant.
`default_nettype none

module htsc_cdiv (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire [htsc_pkg::DIV_W-1:0]          mag,
  input  wire                                neg,
  output logic                               done,
  output logic signed [htsc_pkg::DIV_W:0]    quot
);
  import htsc_pkg::*;

  localparam logic [DIV_W-1:0] DIV_D = DIV_W'(CAL_SAMPLES);

  logic                       v1_r, v2_r, done_r;
  logic [DIV_W-1:0]           m1_r, m2_r;
  logic                       n1_r, n2_r;
  logic [DIV_W-1:0]           q2_r;
  logic [DIV_W+RECIP_W-1:0]   prod;
  logic [DIV_W-1:0]           rem;
  logic [DIV_W-1:0]           q_fix;
  logic signed [DIV_W:0]      quot_r;

  // Reciprocal estimate is the quotient or one below it.
  assign prod  = (DIV_W + RECIP_W)'(m1_r) * (DIV_W + RECIP_W)'(DIV_RECIP);
  assign rem   = m2_r - q2_r * DIV_D;
  assign q_fix = (rem >= DIV_D) ? q2_r + 1'b1 : q2_r;

  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Operand, estimate and corrected result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      m1_r <= mag;
      n1_r <= neg;
    end
    m2_r   <= m1_r;
    n2_r   <= n1_r;
    q2_r   <= prod[DIV_SH +: DIV_W];
    quot_r <= n2_r ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
  end

endmodule

`default_nettype wire

[rtl/core/htsc_back.sv]
// Back part, second stage: step detection, lockout, calibration and output.
// Depends on htsc_pkg and instantiates htsc_cdiv for the offset averages.
`default_nettype none

module htsc_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire                            cfg_index,
  input  wire [htsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                            a_valid,
  input  htsc_pkg::ring_item_t           a_item,
  output logic                           b_ready,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [htsc_pkg::OUT_TDATA_W-1:0] out_tdata,  // azimuth_out, elevation_out,
                                                       // step_detected, calibration_done
  output logic                           out_tuser     // orientation_valid
);
  import htsc_pkg::*;

  localparam logic [CMP_W-1:0] WIN_CMP = CMP_W'(WINDOW);
  localparam logic [SUM_W-1:0] WIN_THR = SUM_W'(WINDOW);

  // Configuration registers.
  logic [SUM_W-1:0]           thr_sc_r;
  logic [15:0]                lockout_r;

  // Stage registers.
  logic                       b_vld_r;
  ring_item_t                 b_r;
  logic                       out_vld_r;
  result_t                    out_r;

  // Detector and calibration state.
  logic                       blocked_r, blocked_nxt;
  logic [15:0]                lock_rem_r, lock_rem_nxt;
  logic [CAL_CNT_W-1:0]       cal_cnt_r, cal_cnt_nxt;
  logic [AZ_TOT_W-1:0]        az_tot_r, az_tot_nxt;
  logic signed [EL_TOT_W-1:0] el_tot_r, el_tot_nxt;
  logic [14:0]                az_off_r;
  logic signed [13:0]         el_off_r;
  logic                       pend_r, pend_nxt;

  logic                       b_fire;
  logic                       div_start;
  logic                       is_samp;
  logic                       is_step;
  logic [SUM_W-1:0]           abs_total;
  logic [CMP_W-1:0]           lhs, rhs;
  logic signed [16:0]         az_diff, az_wrap;
  logic signed [14:0]         el_diff;
  result_t                    res;
  logic [EL_TOT_W-1:0]        el_mag;
  logic                       az_done, el_done;
  logic signed [DIV_W:0]      az_quot, el_quot;

  assign cfg_ready = 1'b1;
  assign b_fire    = b_vld_r && !pend_r && (!out_vld_r || out_tready);
  assign b_ready   = !b_vld_r || b_fire;
  assign is_samp   = (b_r.item.kind == KIND_SAMPLE);

  // Step test: WINDOW*accel > WINDOW*threshold + |sum|.
  assign abs_total = b_r.total[SUM_W-1] ? SUM_W'(-b_r.total) : SUM_W'(b_r.total);
  assign lhs       = CMP_W'(b_r.item.acc[14:0]) * WIN_CMP;
  assign rhs       = CMP_W'(thr_sc_r) + CMP_W'(abs_total);
  assign is_step   = is_samp && !blocked_r && !b_r.item.acc[15] && (lhs > rhs);

  // Offset correction with azimuth wrap.
  assign az_diff = $signed({2'b00, b_r.item.az}) - $signed({2'b00, az_off_r});
  assign az_wrap = az_diff[16] ? az_diff + AZ_FULL_TURN : az_diff;
  assign el_diff = 15'(b_r.item.el) - 15'(el_off_r);

  // Next state of the detector and the calibration, and the result.
  always_comb begin
    blocked_nxt  = blocked_r;
    lock_rem_nxt = lock_rem_r;
    cal_cnt_nxt  = cal_cnt_r;
    az_tot_nxt   = az_tot_r;
    el_tot_nxt   = el_tot_r;
    pend_nxt     = pend_r;
    div_start    = 1'b0;
    res.valid    = 1'b0;
    res.az       = '0;
    res.el       = '0;
    res.step     = is_step;
    res.done     = 1'b0;
    if (b_fire) begin
      case (b_r.item.kind)
        KIND_CAL: begin
          cal_cnt_nxt = CAL_CNT_W'(1);
          az_tot_nxt  = '0;
          el_tot_nxt  = '0;
        end
        KIND_TICK: begin
          if (blocked_r) begin
            if (lock_rem_r <= 16'd1) begin
              lock_rem_nxt = '0;
              blocked_nxt  = 1'b0;
            end else begin
              lock_rem_nxt = lock_rem_r - 1'b1;
            end
          end
        end
        KIND_SAMPLE: begin
          if (is_step) begin
            blocked_nxt  = 1'b1;
            lock_rem_nxt = lockout_r;
          end
          if (cal_cnt_r != '0) begin
            if (cal_cnt_r <= CAL_CNT_W'(CAL_SAMPLES)) begin
              az_tot_nxt  = az_tot_r + AZ_TOT_W'(b_r.item.az);
              el_tot_nxt  = el_tot_r + EL_TOT_W'(b_r.item.el);
              cal_cnt_nxt = cal_cnt_r + 1'b1;
            end else begin
              cal_cnt_nxt = '0;
              div_start   = 1'b1;
              pend_nxt    = 1'b1;
              res.done    = 1'b1;
            end
          end else begin
            res.valid = 1'b1;
            res.az    = az_wrap[14:0];
            res.el    = el_diff;
          end
        end
        default: begin
        end
      endcase
    end
    if (az_done) begin
      pend_nxt = 1'b0;
    end
  end

  // Offset averages.
  assign el_mag = el_tot_r[EL_TOT_W-1] ? EL_TOT_W'(-el_tot_r) : EL_TOT_W'(el_tot_r);

  htsc_cdiv u_az_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (DIV_W'(az_tot_r)),
    .neg   (1'b0),
    .done  (az_done),
    .quot  (az_quot)
  );

  htsc_cdiv u_el_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (DIV_W'(el_mag)),
    .neg   (el_tot_r[EL_TOT_W-1]),
    .done  (el_done),
    .quot  (el_quot)
  );

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_sc_r   <= THR_SC_RESET;
      lockout_r  <= LOCKOUT_RESET;
      b_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      blocked_r  <= 1'b0;
      lock_rem_r <= '0;
      cal_cnt_r  <= '0;
      az_tot_r   <= '0;
      el_tot_r   <= '0;
      az_off_r   <= '0;
      el_off_r   <= '0;
      pend_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_STEP_THRESHOLD: thr_sc_r  <= SUM_W'(cfg_data[14:0]) * WIN_THR;
          REG_LOCKOUT_TICKS:  lockout_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (b_ready) begin
        b_vld_r <= a_valid;
      end
      if (b_fire && is_samp) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      blocked_r  <= blocked_nxt;
      lock_rem_r <= lock_rem_nxt;
      cal_cnt_r  <= cal_cnt_nxt;
      az_tot_r   <= az_tot_nxt;
      el_tot_r   <= el_tot_nxt;
      pend_r     <= pend_nxt;
      if (az_done) begin
        az_off_r <= az_quot[14:0];
      end
      if (el_done) begin
        el_off_r <= el_quot[13:0];
      end
    end
  end

  // Stage and output payload.
  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_r <= a_item;
    end
    if (b_fire && is_samp) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.done, out_r.step, out_r.el, out_r.az};
  assign out_tuser  = out_r.valid;

endmodule

`default_nettype wire

[rtl/core/head_tracker_sample_conditioner_top.sv]
// A sample's result is presented after the item passes through the queue, the ring read
// stage, the detector stage and the output register.
// Throughput: one item per cycle while the receiver does not stall; the sample that
// ends a calibration holds the detector stage while the offset divider pipeline runs.
// Reset is synchronous and active low; ring entry valid bits clear at once, so
// there is no clearing pass.
`default_nettype none

module head_tracker_sample_conditioner_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [htsc_pkg::IN_TDATA_W-1:0]   in_tdata,   // azimuth_in [14:0], elevation_in [28:15],
                                                       // accel_z [44:29], zero pad
  input  wire [htsc_pkg::IN_TUSER_W-1:0]   in_tuser,   // opcode
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [htsc_pkg::OUT_TDATA_W-1:0] out_tdata,  // azimuth_out [14:0], elevation_out [29:15],
                                                       // step_detected [30], calibration_done [31]
  output logic                             out_tuser,  // orientation_valid
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire                              cfg_index,
  input  wire [htsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import htsc_pkg::*;

  logic       q_valid;
  logic       q_pop;
  item_t      q_item;
  logic       a_valid;
  logic       b_ready;
  ring_item_t a_item;

  htsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  htsc_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .b_ready (b_ready),
    .a_valid (a_valid),
    .a_out   (a_item)
  );

  htsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .a_valid    (a_valid),
    .a_item     (a_item),
    .b_ready    (b_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[bench/htsc_result_checker.sv]
// Result checker for the head tracker sample conditioner: watches the input,
// configuration and result channels, predicts each result and compares it.
// Depends on htsc_pkg for widths, opcodes, register indexes and the result type.
module htsc_result_checker
  import htsc_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  input  wire                     in_tready,
  input  wire [IN_TDATA_W-1:0]    in_tdata,   // azimuth_in, elevation_in, accel_z, zero pad
  input  wire [IN_TUSER_W-1:0]    in_tuser,   // opcode
  input  wire                     out_tvalid,
  input  wire                     out_tready,
  input  wire [OUT_TDATA_W-1:0]   out_tdata,  // azimuth_out, elevation_out, step, cal done
  input  wire                     out_tuser,  // orientation_valid
  input  wire                     cfg_valid,
  input  wire                     cfg_ready,
  input  wire                     cfg_index,
  input  wire [CFG_DATA_W-1:0]    cfg_data,
  output int                      mismatches,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  // Register copies.
  int unsigned threshold_reg;
  int unsigned lockout_reg;

  // Step detector state: acceleration history and its running sum.
  logic signed [15:0] accel_window [WINDOW];
  int unsigned        window_slot;
  longint             window_sum;
  bit                 steps_held;
  int unsigned        hold_ticks_left;

  // Calibration state and the offsets in use.
  int unsigned        cal_progress;
  longint             az_cal_sum;
  longint             el_cal_sum;
  int                 az_zero;
  int                 el_zero;

  result_t            conditioned_q [$];
  int                 error_total;

  task automatic log_mismatch(input string msg);
    error_total++;
    if (error_total <= PRINT_LIMIT)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Advance the model by one accepted item; a sample queues its result.
  function automatic void condition_sample(input logic [1:0] op, input logic [14:0] az,
                                           input logic signed [13:0] el,
                                           input logic signed [15:0] acc);
    result_t res;
    longint  mag;
    int      az_diff;
    int      el_diff;
    case (op)
      OP_CAL: begin
        cal_progress = 1;
        az_cal_sum = 0;
        el_cal_sum = 0;
      end
      OP_TICK: begin
        if (steps_held) begin
          if (hold_ticks_left <= 1) begin
            hold_ticks_left = 0;
            steps_held = 1'b0;
          end else begin
            hold_ticks_left--;
          end
        end
      end
      OP_SAMPLE: begin
        res = '0;
        // The sum includes the new sample before the comparison.
        window_sum = window_sum + longint'(acc) - longint'(accel_window[window_slot]);
        accel_window[window_slot] = acc;
        window_slot = (window_slot == WINDOW - 1) ? 0 : window_slot + 1;
        if (!steps_held && acc >= 0) begin
          mag = (window_sum < 0) ? -window_sum : window_sum;
          if (WINDOW * longint'(acc) - mag > WINDOW * longint'(threshold_reg)) begin
            res.step = 1'b1;
            steps_held = 1'b1;
            hold_ticks_left = lockout_reg;
          end
        end
        if (cal_progress != 0) begin
          // Samples are summed; the one after them sets the offsets.
          if (cal_progress <= CAL_SAMPLES) begin
            az_cal_sum += az;
            el_cal_sum += el;
            cal_progress++;
          end else begin
            az_zero = az_cal_sum / CAL_SAMPLES;
            el_zero = el_cal_sum / CAL_SAMPLES;
            cal_progress = 0;
            res.done = 1'b1;
          end
        end else begin
          res.valid = 1'b1;
          az_diff = int'(az) - az_zero;
          if (az_diff < 0)
            az_diff += AZ_FULL_TURN;
          el_diff = int'(el) - el_zero;
          res.az = az_diff[14:0];
          res.el = el_diff[14:0];
        end
        conditioned_q.push_back(res);
      end
      default: ;  // unused opcode leaves the state alone
    endcase
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      threshold_reg = THR_RESET;
      lockout_reg = LOCKOUT_RESET;
      foreach (accel_window[i]) accel_window[i] = '0;
      window_slot = 0;
      window_sum = 0;
      steps_held = 1'b0;
      hold_ticks_left = 0;
      cal_progress = 0;
      az_cal_sum = 0;
      el_cal_sum = 0;
      az_zero = 0;
      el_zero = 0;
      conditioned_q.delete();
      error_total = 0;
    end else begin
      // Compare a result against the oldest prediction.
      if (out_tvalid === 1'b1 && out_tready) begin
        got.valid = out_tuser;
        got.az = out_tdata[14:0];
        got.el = out_tdata[29:15];
        got.step = out_tdata[30];
        got.done = out_tdata[31];
        if (conditioned_q.size() == 0) begin
          log_mismatch($sformatf("result %h/%b with none expected", out_tdata, out_tuser));
        end else begin
          want = conditioned_q.pop_front();
          if (got.valid !== want.valid)
            log_mismatch($sformatf("orientation_valid %b, want %b", got.valid, want.valid));
          if (got.az !== want.az)
            log_mismatch($sformatf("azimuth_out %0d, want %0d", got.az, want.az));
          if (got.el !== want.el)
            log_mismatch($sformatf("elevation_out %0d, want %0d", got.el, want.el));
          if (got.step !== want.step)
            log_mismatch($sformatf("step_detected %b, want %b", got.step, want.step));
          if (got.done !== want.done)
            log_mismatch($sformatf("calibration_done %b, want %b", got.done, want.done));
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_THRESHOLD)
          threshold_reg = cfg_data[14:0];
        else
          lockout_reg = cfg_data;
      end
      // Accepted items.
      if (in_tvalid && in_tready)
        condition_sample(in_tuser, in_tdata[14:0], in_tdata[28:15], in_tdata[44:29]);
    end
    outstanding <= conditioned_q.size();
    mismatches <= error_total;
  end

endmodule

[bench/tb_head_tracker_sample_conditioner_top.sv]
// Testbench top for the head tracker sample conditioner: clock, reset, directed
// and random items, register phases and the verdict. Depends on htsc_pkg,
// the block itself and htsc_result_checker.
module tb_head_tracker_sample_conditioner_top;
  import htsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 450;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;  // azimuth_in, elevation_in, accel_z, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;  // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // azimuth_out, elevation_out, step, cal done
  logic                   out_tuser;       // orientation_valid
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  head_tracker_sample_conditioner_top u_dut (.*);

  htsc_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, one decision per cycle.
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Present one item; tvalid stays high after acceptance unless a gap follows.
  task automatic send_item(input logic [1:0] op, input logic [14:0] az,
                           input logic signed [13:0] el, input logic signed [15:0] acc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, acc, el, az};
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait until every predicted result has come, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [14:0] threshold, input logic [15:0] lockout);
    cfg_valid <= 1'b1;
    cfg_index <= REG_STEP_THRESHOLD;
    cfg_data <= {1'b0, threshold};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_LOCKOUT_TICKS;
    cfg_data <= lockout;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One phase: registers, a calibration, then random items.
  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [14:0] threshold, input logic [15:0] lockout);
    int          sent;
    int          roll;
    int          az_v;
    int          el_v;
    int          acc_v;
    logic [1:0]  op;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    program_regs(threshold, lockout);
    send_item(OP_CAL, '0, '0, '0);
    while (sent < PHASE_ITEMS) begin
      roll = $urandom_range(999);
      if (roll < 2)
        op = OP_CAL;
      else if (roll < 10)
        op = OP_UNUSED;
      else if (roll < 230)
        op = OP_TICK;
      else
        op = OP_SAMPLE;

      // Azimuth: mostly in range, some out of range and at the edges.
      roll = $urandom_range(99);
      if (roll < 80)
        az_v = $urandom_range(23039);
      else if (roll < 90)
        az_v = $urandom_range(32767);
      else if (roll < 95)
        az_v = $urandom_range(63);
      else
        az_v = 23039 - $urandom_range(63);

      roll = $urandom_range(99);
      if (roll < 80)
        el_v = int'($urandom_range(11520)) - 5760;
      else if (roll < 95)
        el_v = int'($urandom_range(16383)) - 8192;
      else
        el_v = ($urandom_range(1) != 0) ? 5760 : -5760;

      // Acceleration: quiet noise with occasional spikes that make steps.
      roll = $urandom_range(99);
      if (roll < 60)
        acc_v = int'($urandom_range(800)) - 400;
      else if (roll < 85)
        acc_v = $urandom_range(32767);
      else if (roll < 95)
        acc_v = int'($urandom_range(65535)) - 32768;
      else
        acc_v = -int'($urandom_range(32768));

      send_item(op, az_v[14:0], el_v[13:0], acc_v[15:0]);
      if (op != OP_UNUSED)
        sent++;
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset register values.
    send_item(OP_TICK, '0, '0, '0);                      // tick while not locked out
    send_item(OP_SAMPLE, 15'd0, 14'sd0, 16'sd156);        // just over the reset threshold
    send_item(OP_SAMPLE, 15'd23039, 14'sd5760, 16'sd32767);
    send_item(OP_TICK, '0, '0, '0);                      // tick during lockout
    send_item(OP_SAMPLE, 15'h7FFF, -14'sd5760, 16'sh8000); // azimuth out of range
    send_item(OP_SAMPLE, 15'd0, 14'sh1FFF, 16'sd0);
    send_item(OP_SAMPLE, 15'h5555, 14'sh2000, 16'sh5555);
    send_item(OP_UNUSED, 15'h7FFF, 14'sh3FFF, 16'shFFFF); // ignored opcode
    send_item(OP_CAL, '0, '0, '0);
    send_item(OP_SAMPLE, 15'd23039, 14'sd5760, 16'sd100);  // sample while calibrating
    send_item(OP_SAMPLE, 15'd0, -14'sd5760, -16'sd100);
    send_item(OP_CAL, '0, '0, '0);                       // restart the calibration
    send_item(OP_SAMPLE, 15'h2AAA, 14'sh2AAA, 16'shAAAA);
    send_item(OP_TICK, '0, '0, '0);
    settle();

    // Random phases across idling patterns and register settings.
    run_phase(0, 0, 15'd0, 16'd0);
    run_phase(55, 0, 15'($urandom_range(3000, 40)), 16'd1);
    run_phase(0, 55, 15'($urandom_range(3000, 40)), 16'($urandom_range(40, 2)));
    run_phase(7, 7, 15'd32767, 16'd65535);

    if (mismatches == 0)
      $display("tb_head_tracker_sample_conditioner_top OK");
    else
      $display("tb_head_tracker_sample_conditioner_top NOT OK");
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_head_tracker_sample_conditioner_top NOT OK");
    $finish;
  end

endmodule
